// ----- rtl/tcarg_pkg.sv -----
// Shared types, constants and helper functions for the ternary cellular automaton generator.
// Has no dependencies; every other file in rtl refers to it by scoped names.
package tcarg_pkg;

    // Field and register widths fixed by the interface.
    localparam int TRIT_W       = 2;
    localparam int RULE_ENTRIES = 27;
    localparam int RULE_W       = 54;
    localparam int WARM_W       = 10;
    localparam int SEED_W       = 40;
    localparam int VALUE_W      = 32;
    localparam int CFG_IDX_W    = 1;

    // Neighbourhood weights used to form the rule index.
    localparam logic [4:0] LEFT_WEIGHT = 5'd9;
    localparam logic [4:0] SELF_WEIGHT = 5'd3;
    localparam logic [4:0] LAST_ENTRY  = 5'd26;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RULE_TABLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_STEPS = 1'b1;

    // Register reset values.
    localparam logic [RULE_W-1:0] RULE_RESET   = 54'd6796640948097636;
    localparam logic [WARM_W-1:0] WARMUP_RESET = 10'd51;

    localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'd0;
    localparam logic [TRIT_W-1:0] TRIT_ONE  = 2'd1;
    localparam logic [TRIT_W-1:0] TRIT_TWO  = 2'd2;
    localparam logic [TRIT_W-1:0] TRIT_BAD  = 2'd3;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WARM,
        ST_GEN,
        ST_CONV
    } state_t;

    // Control shared by every cell of the ring.
    typedef struct packed {
        logic load;
        logic step;
    } ring_ctl_t;

    // A two-bit code of three counts as two.
    function automatic logic [TRIT_W-1:0] clamp_trit(input logic [TRIT_W-1:0] v);
        logic [TRIT_W-1:0] r;
        r = (v == TRIT_BAD) ? TRIT_TWO : v;
        return r;
    endfunction

endpackage

// ----- rtl/ternary_ca_random_generator.sv -----
// A generate transaction steps the ring when accepted, then the converter reads the DIGITS window
// cells, DIGITS being the smaller of WINDOW and CELLS; the next transaction is taken once the result is loaded.
// A seed transaction loads the ring and then runs warmup_steps generations, one per cycle,
// and the next transaction is taken once the warm-up is done.
// Generate results come from the digit-serial base-3 converter reading the ring window.
// Reset (synchronous, aresetn low): ring to all zero with the last cell one, registers to defaults.
module ternary_ca_random_generator #(
    parameter int CELLS  = 51,
    parameter int WINDOW = 20
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [39:0]                            s_tdata,   // [39:0] seed_trits
    input  logic                                   s_tuser,   // [0] kind
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [63:0]                            m_tdata,   // [31:0] random_value, [63:32] stream_word
    // Configuration write port
    input  logic                                   cfg_we,
    input  logic [tcarg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tcarg_pkg::RULE_W-1:0]           cfg_wdata
);

    localparam int DIGITS = (WINDOW < CELLS) ? WINDOW : CELLS;

    tcarg_pkg::state_t                          state_reg;
    tcarg_pkg::state_t                          state_next;
    tcarg_pkg::ring_ctl_t                       ring_ctl;
    logic [tcarg_pkg::RULE_W-1:0]               rule_table_reg;
    logic [tcarg_pkg::WARM_W-1:0]               warmup_steps_reg;
    logic [tcarg_pkg::WARM_W-1:0]               warm_cnt_reg;
    logic [tcarg_pkg::WARM_W-1:0]               warm_cnt_next;
    logic [CELLS-1:0][tcarg_pkg::TRIT_W-1:0]    cell_q;
    logic [DIGITS-1:0][tcarg_pkg::TRIT_W-1:0]   window;
    logic                                       s_accept;
    logic                                       conv_start;
    logic                                       conv_busy;
    logic                                       out_load;
    logic [tcarg_pkg::VALUE_W-1:0]              conv_value;
    logic                                       m_tvalid_reg;
    logic                                       m_tvalid_next;
    logic [tcarg_pkg::VALUE_W-1:0]              value_reg;
    logic [tcarg_pkg::VALUE_W-1:0]              value_rev;

    assign s_accept = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_table_reg   <= tcarg_pkg::RULE_RESET;
            warmup_steps_reg <= tcarg_pkg::WARMUP_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                tcarg_pkg::REG_RULE_TABLE: begin
                    rule_table_reg <= cfg_wdata;
                end
                tcarg_pkg::REG_WARMUP_STEPS: begin
                    warmup_steps_reg <= cfg_wdata[tcarg_pkg::WARM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcarg_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        state_next = tcarg_pkg::ST_GEN;
                    end else if (warmup_steps_reg != '0) begin
                        state_next = tcarg_pkg::ST_WARM;
                    end
                end
            end
            tcarg_pkg::ST_WARM: begin
                if (warm_cnt_reg == tcarg_pkg::WARM_W'(1)) begin
                    state_next = tcarg_pkg::ST_IDLE;
                end
            end
            tcarg_pkg::ST_GEN: begin
                state_next = tcarg_pkg::ST_CONV;
            end
            tcarg_pkg::ST_CONV: begin
                if (out_load) begin
                    state_next = tcarg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcarg_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready      = (state_reg == tcarg_pkg::ST_IDLE);
        ring_ctl.load = s_tvalid && (state_reg == tcarg_pkg::ST_IDLE) && !s_tuser;
        ring_ctl.step = (s_tvalid && (state_reg == tcarg_pkg::ST_IDLE) && s_tuser)
                     || (state_reg == tcarg_pkg::ST_WARM);
        conv_start    = (state_reg == tcarg_pkg::ST_GEN);
        out_load      = (state_reg == tcarg_pkg::ST_CONV) && !conv_busy
                     && (!m_tvalid_reg || m_tready);
    end

    // Warm-up generation counter.
    always_comb begin
        warm_cnt_next = warm_cnt_reg;
        if (ring_ctl.load) begin
            warm_cnt_next = warmup_steps_reg;
        end else if (state_reg == tcarg_pkg::ST_WARM) begin
            warm_cnt_next = warm_cnt_reg - tcarg_pkg::WARM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tcarg_pkg::ST_IDLE;
            warm_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            warm_cnt_reg <= warm_cnt_next;
        end
    end

    // Ring of cells; each sees its wrap-around neighbours.
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        logic [tcarg_pkg::TRIT_W-1:0] seed_trit;

        if (i == CELLS - 1) begin : g_last
            assign seed_trit = tcarg_pkg::TRIT_ONE;
        end else if (i < WINDOW) begin : g_win
            assign seed_trit = tcarg_pkg::clamp_trit(s_tdata[2*i +: tcarg_pkg::TRIT_W]);
        end else begin : g_rest
            assign seed_trit = tcarg_pkg::TRIT_ZERO;
        end

        tcarg_cell #(
            .RESET_VAL((i == CELLS - 1) ? tcarg_pkg::TRIT_ONE : tcarg_pkg::TRIT_ZERO)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ring_ctl),
            .rule_table (rule_table_reg),
            .seed_trit  (seed_trit),
            .left_trit  (cell_q[(i + CELLS - 1) % CELLS]),
            .right_trit (cell_q[(i + 1) % CELLS]),
            .trit       (cell_q[i])
        );
    end

    // Window cells, cell 0 first.
    for (genvar d = 0; d < DIGITS; d++) begin : g_win_tap
        assign window[d] = cell_q[d];
    end

    tcarg_b3conv #(
        .DIGITS(DIGITS)
    ) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .digits  (window),
        .busy    (conv_busy),
        .value   (conv_value)
    );

    // Output register: a new result loads once the previous transaction is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            value_reg <= conv_value;
        end
    end

    // The stream word is the value with its bit order reversed.
    always_comb begin
        for (int b = 0; b < tcarg_pkg::VALUE_W; b++) begin
            value_rev[b] = value_reg[tcarg_pkg::VALUE_W-1-b];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {value_rev, value_reg};

`ifndef NO_ASSERTIONS
    // The ring must stay frozen while the converter reads the window.
    a_ring_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_busy |-> (!ring_ctl.step && !ring_ctl.load))
        else $error("ring changed during conversion");

    // The converter only runs inside the conversion state.
    a_conv_state: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_busy |-> (state_reg == tcarg_pkg::ST_CONV))
        else $error("converter busy outside conversion");

    // Warm-up never sits on an exhausted counter.
    a_warm_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcarg_pkg::ST_WARM) |-> (warm_cnt_reg != '0))
        else $error("warm-up state with zero count");

    // A seed with no warm-up leaves the block ready in the next cycle.
    a_seed_nowarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_tuser && (warmup_steps_reg == '0)) |=> s_tready)
        else $error("not ready after seed without warm-up");
`endif

endmodule

// ----- rtl/tcarg_cell.sv -----
// One cell of the automaton ring: holds a trit and applies the rule table to its neighbourhood.
// Depends on tcarg_pkg for widths, the control struct and the trit clamp.
module tcarg_cell #(
    parameter logic [1:0] RESET_VAL = 2'd0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tcarg_pkg::ring_ctl_t        ctl,
    input  logic [tcarg_pkg::RULE_W-1:0] rule_table,
    input  logic [tcarg_pkg::TRIT_W-1:0] seed_trit,
    input  logic [tcarg_pkg::TRIT_W-1:0] left_trit,
    input  logic [tcarg_pkg::TRIT_W-1:0] right_trit,
    output logic [tcarg_pkg::TRIT_W-1:0] trit
);

    logic [tcarg_pkg::TRIT_W-1:0] trit_reg;
    logic [tcarg_pkg::TRIT_W-1:0] trit_next;
    logic [4:0]                   idx;
    logic [4:0]                   idx_safe;
    logic [tcarg_pkg::TRIT_W-1:0] rule_entry;

    // Rule index from the left, own and right trits.
    always_comb begin
        idx = 5'(left_trit) * tcarg_pkg::LEFT_WEIGHT
            + 5'(trit_reg) * tcarg_pkg::SELF_WEIGHT
            + 5'(right_trit);
        idx_safe   = (idx > tcarg_pkg::LAST_ENTRY) ? tcarg_pkg::LAST_ENTRY : idx;
        rule_entry = tcarg_pkg::clamp_trit(rule_table[{idx_safe, 1'b0} +: tcarg_pkg::TRIT_W]);
    end

    // Load takes priority; otherwise a step moves to the next generation.
    always_comb begin
        trit_next = trit_reg;
        if (ctl.load) begin
            trit_next = seed_trit;
        end else if (ctl.step) begin
            trit_next = rule_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trit_reg <= RESET_VAL;
        end else begin
            trit_reg <= trit_next;
        end
    end

    assign trit = trit_reg;

endmodule

// ----- rtl/tcarg_b3conv.sv -----
// Digit-serial base-3 to binary converter, one trit per cycle, most significant first.
// Depends on tcarg_pkg for widths.
module tcarg_b3conv #(
    parameter int DIGITS = 20
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic [DIGITS-1:0][tcarg_pkg::TRIT_W-1:0] digits,
    output logic                                    busy,
    output logic [tcarg_pkg::VALUE_W-1:0]           value
);

    localparam int CNT_W = $clog2(DIGITS + 1);

    logic [CNT_W-1:0]                          cnt_reg;
    logic [CNT_W-1:0]                          cnt_next;
    logic [DIGITS-1:0][tcarg_pkg::TRIT_W-1:0]  dig_reg;
    logic [DIGITS-1:0][tcarg_pkg::TRIT_W-1:0]  dig_next;
    logic [tcarg_pkg::VALUE_W-1:0]             acc_reg;
    logic [tcarg_pkg::VALUE_W-1:0]             acc_next;

    assign busy = (cnt_reg != '0);

    // Multiply by three as a shift and add, then add the leading digit.
    always_comb begin
        cnt_next = cnt_reg;
        dig_next = dig_reg;
        acc_next = acc_reg;
        if (start) begin
            cnt_next = CNT_W'(DIGITS);
            dig_next = digits;
            acc_next = '0;
        end else if (busy) begin
            cnt_next = cnt_reg - CNT_W'(1);
            acc_next = acc_reg + {acc_reg[tcarg_pkg::VALUE_W-2:0], 1'b0}
                     + tcarg_pkg::VALUE_W'(dig_reg[0]);
            for (int i = 0; i < DIGITS - 1; i++) begin
                dig_next[i] = dig_reg[i+1];
            end
            dig_next[DIGITS-1] = tcarg_pkg::TRIT_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Digit shift register and accumulator are payload and need no reset.
    always_ff @(posedge aclk) begin
        dig_reg <= dig_next;
        acc_reg <= acc_next;
    end

    assign value = acc_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the ternary cellular automaton random generator.
// Depends on rtl/tcarg_pkg.sv and on ternary_ca_random_generator with its cells in rtl.
// A directed table runs first, then random phases; every word is checked against a ring model or a typed value.
module tb_top;

    localparam int CELLS       = 51;
    localparam int WINDOW      = 20;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;
    localparam int PLAN_LEN    = 28;

    // Item kinds carried on s_tuser.
    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_GEN  = 1'b1;

    // Operations of the directed table.
    typedef enum logic [1:0] {
        ROW_SEED,
        ROW_GEN,
        ROW_CFG_RULE,
        ROW_CFG_WARM
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic [63:0] arg;
        logic        typed;
        logic [31:0] value;
    } plan_row_t;

    // Directed stimulus. A typed value replaces the ring model's word for that row.
    plan_row_t plan_rows [0:PLAN_LEN-1] = '{
        '{ROW_GEN,      64'd0,                          1'b1, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_SEED,     64'd0,                          1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_SEED,     64'hFF_FFFF_FFFF,               1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_SEED,     64'hAA_AAAA_AAAA,               1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_SEED,     64'h55_5555_5555,               1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_CFG_RULE, 64'd0,                          1'b0, 32'd0},
        '{ROW_CFG_WARM, 64'd0,                          1'b0, 32'd0},
        '{ROW_SEED,     64'h12_3456_789A,               1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b1, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b1, 32'd0},
        '{ROW_CFG_RULE, 64'h3F_FFFF_FFFF_FFFF,          1'b0, 32'd0},
        '{ROW_SEED,     64'd0,                          1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b1, 32'd3486784400},
        '{ROW_CFG_RULE, 64'(tcarg_pkg::RULE_RESET),     1'b0, 32'd0},
        '{ROW_CFG_WARM, 64'd1023,                       1'b0, 32'd0},
        '{ROW_SEED,     64'hC3_96A5_0F1E,               1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_SEED,     64'hC3_96A5_0F1E,               1'b0, 32'd0},
        '{ROW_SEED,     64'h0F_0F0F_0F0F,               1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_GEN,      64'd0,                          1'b0, 32'd0},
        '{ROW_CFG_WARM, 64'(tcarg_pkg::WARMUP_RESET),   1'b0, 32'd0}
    };

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [tcarg_pkg::SEED_W-1:0]    s_tdata   = '0;
    logic                            s_tuser   = KIND_SEED;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b1;
    logic [63:0]                     m_tdata;
    logic                            cfg_we    = 1'b0;
    logic [tcarg_pkg::CFG_IDX_W-1:0] cfg_index = tcarg_pkg::REG_RULE_TABLE;
    logic [tcarg_pkg::RULE_W-1:0]    cfg_wdata = '0;

    // Ring model state and its copy of the registers.
    logic [tcarg_pkg::TRIT_W-1:0] ring [CELLS];
    logic [tcarg_pkg::RULE_W-1:0] rule_reg;
    logic [tcarg_pkg::WARM_W-1:0] warm_reg;

    // Words still owed by the block, oldest first: {stream_word, random_value}.
    logic [63:0] expected_words [$];

    logic idle_on    = 1'b1;
    int   hold_left  = 0;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   words_checked = 0;
    int   seeds_sent = 0;
    int   gens_sent  = 0;
    int   settings_used = 0;

    // Clock: period of 8 time units.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    ternary_ca_random_generator #(
        .CELLS  (CELLS),
        .WINDOW (WINDOW)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [39:0] seed_trits
        .s_tuser   (s_tuser),    // [0] kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [31:0] random_value, [63:32] stream_word
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // One generation of the whole ring, all cells at once with wraparound.
    function automatic void advance_ring();
        logic [tcarg_pkg::TRIT_W-1:0] nxt [CELLS];
        int left, right, idx;
        logic [tcarg_pkg::TRIT_W-1:0] entry;
        for (int i = 0; i < CELLS; i++) begin
            left  = (i == 0) ? CELLS - 1 : i - 1;
            right = (i == CELLS - 1) ? 0 : i + 1;
            idx   = 9 * ring[left] + 3 * ring[i] + ring[right];
            entry = rule_reg[2*idx +: 2];
            nxt[i] = (entry == tcarg_pkg::TRIT_BAD) ? tcarg_pkg::TRIT_TWO : entry;
        end
        ring = nxt;
    endfunction

    // Seed load followed by the silent warm-up generations.
    function automatic void load_ring(logic [tcarg_pkg::SEED_W-1:0] seed);
        logic [tcarg_pkg::TRIT_W-1:0] t;
        for (int i = 0; i < CELLS; i++) begin
            t = (i < WINDOW) ? seed[2*i +: 2] : tcarg_pkg::TRIT_ZERO;
            ring[i] = (t == tcarg_pkg::TRIT_BAD) ? tcarg_pkg::TRIT_TWO : t;
        end
        ring[CELLS-1] = tcarg_pkg::TRIT_ONE;
        for (int n = 0; n < int'(warm_reg); n++)
            advance_ring();
    endfunction

    function automatic logic [31:0] mirror(logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
            r[31-i] = v[i];
        return r;
    endfunction

    // Advances the ring and reads the window as a base-3 number, first cell most significant.
    function automatic logic [63:0] next_word();
        logic [63:0] acc;
        logic [31:0] val;
        advance_ring();
        acc = '0;
        for (int i = 0; i < WINDOW; i++)
            acc = acc * 3 + 64'(ring[i]);
        val = acc[31:0];
        return {mirror(val), val};
    endfunction

    // Offers one transaction and updates the model once it is taken.
    task automatic offer(logic kind, logic [tcarg_pkg::SEED_W-1:0] seed, logic typed,
                         logic [31:0] value);
        logic [63:0] w;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= seed;
        do @(posedge aclk); while (!s_tready);
        if (kind == KIND_SEED) begin
            load_ring(seed);
            seeds_sent++;
        end else begin
            w = next_word();
            if (typed)
                w = {mirror(value), value};
            expected_words.push_back(w);
            gens_sent++;
        end
        // Random sender gap after the transaction.
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Stops sending, lets every owed word arrive and any warm-up run out.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (int'(warm_reg) + 40) @(posedge aclk);
    endtask

    task automatic set_reg(logic [tcarg_pkg::CFG_IDX_W-1:0] idx,
                           logic [tcarg_pkg::RULE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == tcarg_pkg::REG_RULE_TABLE)
            rule_reg = data;
        else
            warm_reg = data[tcarg_pkg::WARM_W-1:0];
        @(posedge aclk);
    endtask

    // Stimulus: directed table, then random phases.
    initial begin : stimulus
        logic [tcarg_pkg::RULE_W-1:0] rule_pick;
        logic [tcarg_pkg::WARM_W-1:0] warm_pick;
        logic [tcarg_pkg::SEED_W-1:0] seed;
        int reseed_odds;

        for (int i = 0; i < CELLS; i++)
            ring[i] = tcarg_pkg::TRIT_ZERO;
        ring[CELLS-1] = tcarg_pkg::TRIT_ONE;
        rule_reg = tcarg_pkg::RULE_RESET;
        warm_reg = tcarg_pkg::WARMUP_RESET;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++) begin
            case (plan_rows[r].op)
                ROW_SEED: begin
                    offer(KIND_SEED, plan_rows[r].arg[tcarg_pkg::SEED_W-1:0], 1'b0, 32'd0);
                end
                ROW_GEN: begin
                    offer(KIND_GEN, '0, plan_rows[r].typed, plan_rows[r].value);
                end
                ROW_CFG_RULE: begin
                    quiesce();
                    set_reg(tcarg_pkg::REG_RULE_TABLE,
                            plan_rows[r].arg[tcarg_pkg::RULE_W-1:0]);
                    settings_used++;
                end
                default: begin
                    quiesce();
                    set_reg(tcarg_pkg::REG_WARMUP_STEPS,
                            tcarg_pkg::RULE_W'(plan_rows[r].arg[tcarg_pkg::WARM_W-1:0]));
                    settings_used++;
                end
            endcase
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            quiesce();
            idle_on <= (phase != PHASES - 1) && ($urandom_range(0, 4) != 0);

            case ($urandom_range(0, 5))
                0:       rule_pick = tcarg_pkg::RULE_RESET;
                1:       rule_pick = '1;
                default: rule_pick = tcarg_pkg::RULE_W'({$urandom, $urandom});
            endcase
            // Long warm-ups are kept rare since each seed then runs 512 to 1023 warm-up generations.
            if ($urandom_range(0, 7) == 0)
                warm_pick = tcarg_pkg::WARM_W'($urandom_range(512, 1023));
            else
                warm_pick = tcarg_pkg::WARM_W'($urandom_range(0, 40));
            set_reg(tcarg_pkg::REG_RULE_TABLE, rule_pick);
            set_reg(tcarg_pkg::REG_WARMUP_STEPS, tcarg_pkg::RULE_W'(warm_pick));
            settings_used++;
            reseed_odds = (warm_pick > 64) ? 2 : 12;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                seed = tcarg_pkg::SEED_W'({$urandom, $urandom});
                // Most phases start from a fresh seed; a few run on whatever the ring holds.
                if ((n == 0 && $urandom_range(0, 7) != 0) || $urandom_range(0, 99) < reseed_odds)
                    offer(KIND_SEED, seed, 1'b0, 32'd0);
                else
                    offer(KIND_GEN, seed, 1'b0, 32'd0);
            end
        end

        quiesce();
        $display("Ran %0d seed loads and %0d generate transactions under %0d register settings;",
                 seeds_sent, gens_sent, settings_used);
        $display("%0d words checked, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result side back-pressure in random bursts.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 7);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compares each result transaction with the oldest owed word.
    always @(posedge aclk) begin : check_results
        logic [63:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== want[31:0]) begin
                    $display("%0t: random_value expected %h, got %h",
                             $time, want[31:0], m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[63:32] !== want[63:32]) begin
                    $display("%0t: stream_word expected %h, got %h",
                             $time, want[63:32], m_tdata[63:32]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d words still owed",
                     $time, cycle_count, expected_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
